FILE: design/ddo_pkg.sv
`timescale 1ns / 1ps
package ddo_pkg;

    localparam int CNT_W     = 32;
    localparam int SUM_W     = CNT_W + 1;
    localparam int DELTA_W   = CNT_W + 3;
    localparam int POS_W     = 48;
    localparam int ANG_W     = 32;
    localparam int TRIG_W    = 32;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = DELTA_W + MUL_B_W;
    localparam int ACC_W     = DELTA_W + TRIG_W + 1;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 32'sd163008218;
    localparam logic        [ANG_W-1:0]  EIGHTH_TURN  = 32'h2000_0000;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF   = 68'sd8192;
    localparam logic signed [POS_W-1:0]  POS_MAX      = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [POS_W-1:0]  POS_MIN      = 48'sh8000_0000_0000;

    localparam logic signed [TRIG_W-1:0] ATAN_TAB [32] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5,
        32'sd3,         32'sd1,         32'sd1,         32'sd0
    };

    // travel in quarter counts and wheel difference in half counts
    typedef struct packed {
        logic signed [DELTA_W-1:0] travel;
        logic signed [DELTA_W-1:0] diff;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [ANG_W-1:0] angle;
    } t_trig_req;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_q28;
        logic signed [TRIG_W-1:0] sin_q28;
    } t_trig_rsp;

endpackage

FILE: design/ddo_in_if.sv
`timescale 1ns / 1ps
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_rear_count;
    logic signed [31:0] left_front_count;
    logic signed [31:0] right_rear_count;
    logic signed [31:0] right_front_count;

    modport source (
        output valid, left_rear_count, left_front_count,
               right_rear_count, right_front_count,
        input  ready
    );
    modport sink (
        input  valid, left_rear_count, left_front_count,
               right_rear_count, right_front_count,
        output ready
    );
endinterface

FILE: design/ddo_out_if.sv
`timescale 1ns / 1ps
interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] x_position;
    logic signed [47:0] y_position;
    logic        [31:0] heading_angle;

    modport source (
        output valid, x_position, y_position, heading_angle,
        input  ready
    );
    modport sink (
        input  valid, x_position, y_position, heading_angle,
        output ready
    );
endinterface

FILE: design/ddo_front.sv
`timescale 1ns / 1ps
module ddo_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ddo_in_if.sink         i_in,
    input  logic           i_full,
    output logic           o_push,
    output ddo_pkg::t_job  o_job
);
    import ddo_pkg::*;

    logic signed [SUM_W-1:0]   r_prev_left;
    logic signed [SUM_W-1:0]   r_prev_right;
    logic signed [SUM_W-1:0]   w_lsum;
    logic signed [SUM_W-1:0]   w_rsum;
    logic signed [SUM_W:0]     w_dl;
    logic signed [SUM_W:0]     w_dr;

    assign w_lsum = SUM_W'(i_in.left_rear_count) + SUM_W'(i_in.left_front_count);
    assign w_rsum = SUM_W'(i_in.right_rear_count) + SUM_W'(i_in.right_front_count);
    assign w_dl   = (SUM_W+1)'(w_lsum) - (SUM_W+1)'(r_prev_left);
    assign w_dr   = (SUM_W+1)'(w_rsum) - (SUM_W+1)'(r_prev_right);

    assign i_in.ready   = !i_full;
    assign o_push       = i_in.valid && !i_full;
    assign o_job.travel = DELTA_W'(w_dl) + DELTA_W'(w_dr);
    assign o_job.diff   = DELTA_W'(w_dr) - DELTA_W'(w_dl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_left  <= '0;
            r_prev_right <= '0;
        end else if (o_push) begin
            r_prev_left  <= w_lsum;
            r_prev_right <= w_rsum;
        end
    end

endmodule

FILE: design/ddo_queue.sv
`timescale 1ns / 1ps
module ddo_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ddo_pkg::t_job  i_job,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output ddo_pkg::t_job  o_job
);
    import ddo_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

    t_job               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CNT_W_Q'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_job     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: design/ddo_cordic.sv
`timescale 1ns / 1ps
module ddo_cordic #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ddo_pkg::t_trig_req  i_req,
    output ddo_pkg::t_trig_rsp  o_rsp
);
    import ddo_pkg::*;

    // more than 32 steps behaves as 32
    localparam int         USED_STEPS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP  = 5'(USED_STEPS - 1);

    logic                     r_busy;
    logic                     r_done;
    logic [4:0]               r_step;
    logic [1:0]               r_quad;
    logic signed [TRIG_W-1:0] r_x;
    logic signed [TRIG_W-1:0] r_y;
    logic signed [TRIG_W-1:0] r_z;
    logic signed [TRIG_W-1:0] r_cos;
    logic signed [TRIG_W-1:0] r_sin;
    logic [ANG_W-1:0]         w_rot;
    logic signed [TRIG_W-1:0] n_x;
    logic signed [TRIG_W-1:0] n_y;
    logic signed [TRIG_W-1:0] n_z;

    assign w_rot = i_req.angle + EIGHTH_TURN;

    always_comb begin
        if (!r_z[TRIG_W-1]) begin
            n_x = r_x - (r_y >>> r_step);
            n_y = r_y + (r_x >>> r_step);
            n_z = r_z - ATAN_TAB[r_step];
        end else begin
            n_x = r_x + (r_y >>> r_step);
            n_y = r_y - (r_x >>> r_step);
            n_z = r_z + ATAN_TAB[r_step];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quad <= w_rot[31:30];
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= TRIG_W'({2'b00, w_rot[29:0]}) - TRIG_W'(EIGHTH_TURN);
            end else if (r_busy) begin
                r_x    <= n_x;
                r_y    <= n_y;
                r_z    <= n_z;
                r_step <= r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    case (r_quad)
                        2'd0:    begin r_cos <= n_x;  r_sin <= n_y;  end
                        2'd1:    begin r_cos <= -n_y; r_sin <= n_x;  end
                        2'd2:    begin r_cos <= -n_x; r_sin <= -n_y; end
                        default: begin r_cos <= n_y;  r_sin <= -n_x; end
                    endcase
                end
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.cos_q28 = r_cos;
    assign o_rsp.sin_q28 = r_sin;

endmodule

FILE: design/ddo_back.sv
`timescale 1ns / 1ps
module ddo_back #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [31:0]    i_angle_per_count,
    input  logic           i_valid,
    input  ddo_pkg::t_job  i_job,
    output logic           o_pop,
    ddo_out_if.source      o_out
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A0, ST_MUL_A1, ST_TRIG_START, ST_TRIG_WAIT,
        ST_MUL_Y0, ST_MUL_Y1, ST_MUL_X0, ST_MUL_X1, ST_FINISH
    } t_state;

    t_state                    r_state;
    logic signed [DELTA_W-1:0] r_travel;
    logic signed [DELTA_W-1:0] r_diff;
    logic signed [ACC_W-1:0]   r_acc;
    logic [ANG_W-1:0]          r_dtheta;
    logic [ANG_W-1:0]          r_heading;
    logic signed [POS_W-1:0]   r_x;
    logic signed [POS_W-1:0]   r_y;
    logic                      r_out_valid;
    logic signed [POS_W-1:0]   r_out_x;
    logic signed [POS_W-1:0]   r_out_y;
    logic [ANG_W-1:0]          r_out_heading;
    logic                      r_trig_start;
    logic [ANG_W-1:0]          r_trig_angle;

    t_trig_req                 w_req;
    t_trig_rsp                 w_rsp;
    logic signed [DELTA_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_pp;
    logic signed [ACC_W-1:0]   w_rounded;
    logic signed [ACC_W-15:0]  w_step;
    logic signed [POS_W-1:0]   w_y_sat;
    logic signed [POS_W-1:0]   w_x_sat;
    logic                      w_out_free;

    function automatic logic signed [POS_W-1:0] sat48(input logic signed [POS_W+6:0] v);
        if (v > (POS_W+7)'(POS_MAX)) begin
            return POS_MAX;
        end else if (v < (POS_W+7)'(POS_MIN)) begin
            return POS_MIN;
        end
        return v[POS_W-1:0];
    endfunction

    ddo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_req.start = r_trig_start;
    assign w_req.angle = r_trig_angle;

    // one 35x17 signed multiplier, two passes per product
    always_comb begin
        case (r_state)
            ST_MUL_A0: begin
                w_mul_a = r_diff;
                w_mul_b = {1'b0, i_angle_per_count[15:0]};
            end
            ST_MUL_A1: begin
                w_mul_a = r_diff;
                w_mul_b = {1'b0, i_angle_per_count[31:16]};
            end
            ST_MUL_Y0: begin
                w_mul_a = r_travel;
                w_mul_b = {1'b0, w_rsp.cos_q28[15:0]};
            end
            ST_MUL_Y1: begin
                w_mul_a = r_travel;
                w_mul_b = {w_rsp.cos_q28[31], w_rsp.cos_q28[31:16]};
            end
            ST_MUL_X0: begin
                w_mul_a = r_travel;
                w_mul_b = {1'b0, w_rsp.sin_q28[15:0]};
            end
            default: begin
                w_mul_a = r_travel;
                w_mul_b = {w_rsp.sin_q28[31], w_rsp.sin_q28[31:16]};
            end
        endcase
    end

    assign w_pp       = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    assign w_rounded  = r_acc + ROUND_HALF;
    assign w_step     = w_rounded[ACC_W-1:14];
    assign w_y_sat    = sat48((POS_W+7)'(r_y) + (POS_W+7)'(w_step));
    assign w_x_sat    = sat48((POS_W+7)'(r_x) - (POS_W+7)'(w_step));
    assign w_out_free = !r_out_valid || o_out.ready;
    assign o_pop      = (r_state == ST_IDLE) && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_heading    <= '0;
            r_x          <= '0;
            r_y          <= '0;
            r_out_valid  <= 1'b0;
            r_trig_start <= 1'b0;
        end else begin
            r_trig_start <= 1'b0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_travel <= i_job.travel;
                        r_diff   <= i_job.diff;
                        r_state  <= ST_MUL_A0;
                    end
                end
                ST_MUL_A0: begin
                    r_acc   <= ACC_W'(w_pp);
                    r_state <= ST_MUL_A1;
                end
                ST_MUL_A1: begin
                    r_acc   <= r_acc + (ACC_W'(w_pp) <<< 16);
                    r_state <= ST_TRIG_START;
                end
                ST_TRIG_START: begin
                    r_dtheta     <= r_acc[48:17];
                    r_trig_angle <= r_heading + r_acc[49:18];
                    r_trig_start <= 1'b1;
                    r_state      <= ST_TRIG_WAIT;
                end
                ST_TRIG_WAIT: begin
                    if (w_rsp.done) begin
                        r_state <= ST_MUL_Y0;
                    end
                end
                ST_MUL_Y0: begin
                    r_acc   <= ACC_W'(w_pp);
                    r_state <= ST_MUL_Y1;
                end
                ST_MUL_Y1: begin
                    r_acc   <= r_acc + (ACC_W'(w_pp) <<< 16);
                    r_state <= ST_MUL_X0;
                end
                ST_MUL_X0: begin
                    r_y     <= w_y_sat;
                    r_acc   <= ACC_W'(w_pp);
                    r_state <= ST_MUL_X1;
                end
                ST_MUL_X1: begin
                    r_acc   <= r_acc + (ACC_W'(w_pp) <<< 16);
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (w_out_free) begin
                        r_x           <= w_x_sat;
                        r_heading     <= r_heading + r_dtheta;
                        r_out_x       <= w_x_sat;
                        r_out_y       <= r_y;
                        r_out_heading <= r_heading + r_dtheta;
                        r_out_valid   <= 1'b1;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.x_position    = r_out_x;
    assign o_out.y_position    = r_out_y;
    assign o_out.heading_angle = r_out_heading;

endmodule

FILE: design/differential_drive_odometry_core.sv
`timescale 1ns / 1ps
// Dead-reckoning odometry for a differential drive base. Each request carries
// four raw encoder counts; the block returns one pose (x, y in Q32.16 with
// saturation, heading as a wrapping 32-bit binary angle) per request, in
// order. The front stage differences the side sums against the previous
// request and hands the job to a two-entry queue, so a new request can be
// taken while the back end works. The back end takes one request at a time:
// six passes through one shared 35x17 multiplier, one CORDIC step per cycle,
// and the result register, which can stall on the output handshake.
// angle_per_count is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this.
module differential_drive_odometry_core #(
    parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    ddo_in_if.sink      i_in,
    ddo_out_if.source   o_out
);
    import ddo_pkg::*;

    logic [31:0] r_angle_per_count;
    logic        w_push;
    logic        w_full;
    logic        w_q_valid;
    logic        w_pop;
    t_job        w_push_job;
    t_job        w_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_per_count <= '0;
        end else if (i_cfg_we) begin
            r_angle_per_count <= i_cfg_wdata;
        end
    end

    ddo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    ddo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_q_job)
    );

    ddo_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_angle_per_count (r_angle_per_count),
        .i_valid           (w_q_valid),
        .i_job             (w_q_job),
        .o_pop             (w_pop),
        .o_out             (o_out)
    );

endmodule
